[src/crle_pkg.sv]
// Shared types, constants and the 32-bit saturation function for the Catmull-Rom loop evaluator.
package crle_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned AXES    = 3;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT_MIN = -64'sh0000_0000_8000_0000;

  function automatic coord_t sat32(input logic signed [63:0] x);
    coord_t r;
    if (x > SAT_MAX) begin
      r = coord_t'(SAT_MAX);
    end else if (x < SAT_MIN) begin
      r = coord_t'(SAT_MIN);
    end else begin
      r = coord_t'(x);
    end
    return r;
  endfunction

endpackage

[src/catmull_rom_loop_evaluator.sv]
// Top level: point store, segment addressing and the three axis pipelines.
//
//  channel | signals                          | handshake
//  in      | start, busy, kind..loop_param    | start & !busy
//  cfg     | cfg_valid, cfg_ready, cfg_data   | cfg_valid & cfg_ready
//  out     | done, pos_*, tan_*               | one-cycle strobe
//
// One item per cycle; an evaluate result passes the scale multiply, the index
// stage, the registered store read and the four-stage basis chain per axis.
// A load is registered (wa, wslot, wpt) and then written to both store copies.
// busy is always low: the receiver cannot stall, so the pipeline never holds.
// Reset clears the valid bits and sets loop_len to 4; the point store is not
// cleared.
module catmull_rom_loop_evaluator #(
  parameter int unsigned MAX_POINTS      = 64,
  parameter int unsigned PARAM_FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 kind,
  input  logic [5:0]           point_index,
  input  crle_pkg::coord_t     coord_x,
  input  crle_pkg::coord_t     coord_y,
  input  crle_pkg::coord_t     coord_z,
  input  logic [15:0]          loop_param,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [6:0]           cfg_data,
  output logic                 done,
  output crle_pkg::coord_t     pos_x,
  output crle_pkg::coord_t     pos_y,
  output crle_pkg::coord_t     pos_z,
  output crle_pkg::coord_t     tan_x,
  output crle_pkg::coord_t     tan_y,
  output crle_pkg::coord_t     tan_z
);

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned NW = AW + 1;
  localparam int unsigned FB = PARAM_FRAC_BITS;
  localparam int unsigned LAT = 7;

  logic [6:0] loop_len;
  logic [NW-1:0] n_eff;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_len <= 7'd4;
    end else if (cfg_valid && cfg_ready) begin
      loop_len <= cfg_data;
    end
  end

  always_comb begin
    if (loop_len == 7'd0) begin
      n_eff = NW'(1);
    end else if (32'(loop_len) > MAX_POINTS) begin
      n_eff = NW'(MAX_POINTS);
    end else begin
      n_eff = NW'(loop_len);
    end
  end

  logic accept;
  assign accept = start && !busy;

  // point store, kept twice so that each copy serves two fetch slots
  crle_pkg::point_t mem_lo [MAX_POINTS];
  crle_pkg::point_t mem_hi [MAX_POINTS];
  logic wa;
  logic [AW-1:0] wslot;
  crle_pkg::point_t wpt;

  // hold the load one stage so every earlier evaluate has fetched first
  always_ff @(posedge clk) begin
    if (rst) wa <= 1'b0;
    else wa <= accept && kind == crle_pkg::KIND_LOAD;
    wslot <= AW'(point_index);
    wpt   <= '{x: coord_x, y: coord_y, z: coord_z};
  end

  always_ff @(posedge clk) begin
    if (wa) begin
      mem_lo[wslot] <= wpt;
      mem_hi[wslot] <= wpt;
    end
  end

  // stage A: scale
  logic [FB+NW-1:0] g;
  logic [FB-1:0] fa;
  logic [FB-1:0] t_frac;
  logic [NW-1:0] na;
  logic va;
  assign t_frac = FB'(loop_param);
  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else va <= accept && kind == crle_pkg::KIND_EVAL;
    g  <= (FB+NW)'(t_frac) * (FB+NW)'(n_eff);
    na <= n_eff;
  end

  // stage B: indices with wraparound
  logic [NW-1:0] seg;
  logic [AW-1:0] idx0, idx1, idx2, idx3;
  logic [FB-1:0] fb_;
  logic vb;
  assign seg = NW'(g >> FB);
  assign fa  = g[FB-1:0];

  function automatic logic [AW-1:0] wrap(input logic [NW:0] x, input logic [NW-1:0] n);
    logic [NW:0] r;
    r = (x >= (NW+1)'(n)) ? x - (NW+1)'(n) : x;
    return AW'(r);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else vb <= va;
    idx0 <= wrap((NW+1)'(seg) + (NW+1)'(na) - (NW+1)'(1), na);
    idx1 <= wrap((NW+1)'(seg), na);
    idx2 <= wrap((NW+1)'(seg) + (NW+1)'(1), na);
    idx3 <= wrap((NW+1)'(seg) + (NW+1)'(2) >= (NW+1)'(na) + (NW+1)'(na)
                 ? (NW+1)'(seg) + (NW+1)'(2) - (NW+1)'(na)
                 : (NW+1)'(seg) + (NW+1)'(2), na);
    fb_ <= fa;
  end

  // stage C: registered store read
  crle_pkg::point_t r0, r1, r2, r3;
  logic [FB-1:0] fc;
  logic vc;
  always_ff @(posedge clk) begin
    if (rst) vc <= 1'b0;
    else vc <= vb;
    r0 <= mem_lo[idx0];
    r1 <= mem_lo[idx1];
    r2 <= mem_hi[idx2];
    r3 <= mem_hi[idx3];
    fc <= fb_;
  end

  crle_axis #(.FRAC_BITS(FB)) u_ax (
    .clk(clk), .en(1'b1), .p0(r0.x), .p1(r1.x), .p2(r2.x), .p3(r3.x),
    .frac(fc), .pos(pos_x), .tan(tan_x));
  crle_axis #(.FRAC_BITS(FB)) u_ay (
    .clk(clk), .en(1'b1), .p0(r0.y), .p1(r1.y), .p2(r2.y), .p3(r3.y),
    .frac(fc), .pos(pos_y), .tan(tan_y));
  crle_axis #(.FRAC_BITS(FB)) u_az (
    .clk(clk), .en(1'b1), .p0(r0.z), .p1(r1.z), .p2(r2.z), .p3(r3.z),
    .frac(fc), .pos(pos_z), .tan(tan_z));

  // valid bits across the four axis stages
  logic [3:0] vpipe;
  always_ff @(posedge clk) begin
    if (rst) vpipe <= '0;
    else vpipe <= {vpipe[2:0], vc};
  end
  assign done = vpipe[3];

`ifndef SYNTHESIS
  a_done_lat: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(vc, 4)) else $error("done without evaluate in flight");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    vb |-> (32'(idx1) < MAX_POINTS)) else $error("segment index out of store");
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && kind == crle_pkg::KIND_LOAD) |=> !va) else $error("load raised valid");
`endif

endmodule

[src/crle_axis.sv]
// Per-axis Catmull-Rom basis evaluation, pipelined Horner chain.
module crle_axis #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      en,
  input  crle_pkg::coord_t          p0,
  input  crle_pkg::coord_t          p1,
  input  crle_pkg::coord_t          p2,
  input  crle_pkg::coord_t          p3,
  input  logic [FRAC_BITS-1:0]      frac,
  output crle_pkg::coord_t          pos,
  output crle_pkg::coord_t          tan
);

  localparam int unsigned FW = FRAC_BITS + 1;

  // stage 1: basis sums
  logic signed [35:0] a, b;
  logic signed [33:0] c;
  logic signed [32:0] q1;
  logic [FRAC_BITS-1:0] f1;

  // stage 2: first products
  logic signed [63:0] u, d;
  logic signed [33:0] c2;
  logic signed [32:0] q2;
  logic [FRAC_BITS-1:0] f2;

  // stage 3: second products
  logic signed [63:0] v, tan_full;
  logic signed [32:0] q3;
  logic [FRAC_BITS-1:0] f3;

  // stage 4: final
  logic signed [95:0] pm;
  logic signed [95:0] tm;
  logic signed [95:0] pn;

  logic signed [FW-1:0] sf1, sf2, sf3;
  assign sf1 = $signed({1'b0, f1});
  assign sf2 = $signed({1'b0, f2});
  assign sf3 = $signed({1'b0, f3});

  always_ff @(posedge clk) begin
    if (en) begin
      a  <= -36'(p0) + 36'sd3 * 36'(p1) - 36'sd3 * 36'(p2) + 36'(p3);
      b  <= 36'sd2 * 36'(p0) - 36'sd5 * 36'(p1) + 36'sd4 * 36'(p2) - 36'(p3);
      c  <= 34'(p2) - 34'(p0);
      q1 <= 33'(p1);
      f1 <= frac;

      u  <= (64'(a) * 64'(sf1) + (64'(b) <<< FRAC_BITS)) >>> FRAC_BITS;
      d  <= (64'(a) * 64'(sf1) * 64'sd3 + (64'(b) <<< (FRAC_BITS + 1))) >>> FRAC_BITS;
      c2 <= c;
      q2 <= q1;
      f2 <= f1;

      v  <= (64'(u) * 64'(sf2) + (64'(c2) <<< FRAC_BITS)) >>> FRAC_BITS;
      tan_full <= (64'(d) * 64'(sf2) + (64'(c2) <<< FRAC_BITS)
                   + (64'sd1 <<< FRAC_BITS)) >>> (FRAC_BITS + 1);
      q3 <= q2;
      f3 <= f2;

      pos <= crle_pkg::sat32(64'(pn));
      tan <= crle_pkg::sat32(tan_full);
    end
  end

  always_comb begin
    pm = 96'(v) * 96'(sf3) + (96'sd1 <<< FRAC_BITS);
    tm = pm >>> (FRAC_BITS + 1);
    pn = tm + 96'(q3);
  end

endmodule
